@@ sv/gtpl_pkg.sv @@
// Shared constants, command type and opcodes for the group-test pool likelihood engine.
// No dependencies; used by every module of the block except gtpl_ram.
package gtpl_pkg;

    localparam int MAX_MEMBERS_DEF = 8;
    localparam int NUM_ASSAYS      = 4;
    localparam int REG_ASSAYS      = 4;
    localparam int PROB_FRAC_BITS  = 16;
    localparam int PROB_W          = 17;
    localparam int MASK_W          = 8;
    localparam int ACC_W           = 48;
    localparam int PCNT_W          = 24;
    localparam int ADDR_W          = 5;
    localparam int FIFO_DEPTH      = 4;

    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_FRAC_BITS;
    localparam logic [31:0]       W_ONE    = 32'h8000_0000;
    localparam logic [31:0]       LN2_Q32  = 32'd2977044472;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_TEST = 2'd1;
    localparam logic [1:0] OP_POOL = 2'd2;
    localparam logic [1:0] OP_SET  = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [PROB_W-1:0] prob;
        logic [MASK_W-1:0] mask;
        logic              pos;
        logic [1:0]        assay;
    } cmd_t;

endpackage

@@ sv/gtpl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gtpl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/gtpl_front.sv @@
// Front end: accepts input transactions, classifies them and queues commands.
// Depends on gtpl_pkg.
module gtpl_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic [1:0]                   operation,
    input  logic [gtpl_pkg::PROB_W-1:0]  member_prob,
    input  logic [gtpl_pkg::MASK_W-1:0]  member_mask,
    input  logic                         test_positive,
    input  logic [1:0]                   assay,
    output logic                         cmd_valid,
    output gtpl_pkg::cmd_t               cmd,
    input  logic                         cmd_pop
);

    localparam int PW = $clog2(gtpl_pkg::FIFO_DEPTH);

    gtpl_pkg::cmd_t   fifo_mem [gtpl_pkg::FIFO_DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             push;
    gtpl_pkg::cmd_t   cls;

    // Saturate the probability and clamp the assay here so the back end uses them directly.
    always_comb
    begin
        cls.op    = operation;
        cls.prob  = (member_prob > gtpl_pkg::PROB_ONE) ? gtpl_pkg::PROB_ONE : member_prob;
        cls.mask  = member_mask;
        cls.pos   = test_positive;
        cls.assay = (assay > 2'(gtpl_pkg::NUM_ASSAYS - 1)) ? 2'(gtpl_pkg::NUM_ASSAYS - 1) : assay;
    end

    assign item_stall = (count_reg == (PW+1)'(gtpl_pkg::FIFO_DEPTH));
    assign push       = item_valid && !item_stall;
    assign cmd_valid  = (count_reg != '0);
    assign cmd        = fifo_mem[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? wptr_reg + PW'(1) : wptr_reg;
        rptr_next  = cmd_pop ? rptr_reg + PW'(1) : rptr_reg;
        count_next = count_reg + (PW+1)'(push) - (PW+1)'(cmd_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ sv/gtpl_back.sv @@
// Back end: weight updates, pool sum, fixed-point log and set accumulation, result register.
// Depends on gtpl_pkg and gtpl_ram.
module gtpl_back #(
    parameter int MAX_MEMBERS = gtpl_pkg::MAX_MEMBERS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    input  gtpl_pkg::cmd_t               cmd,
    output logic                         cmd_pop,
    input  logic [gtpl_pkg::PROB_W-1:0]  se_val [gtpl_pkg::REG_ASSAYS],
    input  logic [gtpl_pkg::PROB_W-1:0]  sp_val [gtpl_pkg::REG_ASSAYS],
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [gtpl_pkg::ACC_W-1:0]  log_likelihood,
    output logic [gtpl_pkg::PCNT_W-1:0]  pool_count,
    output logic                         zero_prob_seen
);

    localparam int CW     = MAX_MEMBERS;
    localparam int COMBOS = 1 << MAX_MEMBERS;
    localparam int CNT_W  = $clog2(MAX_MEMBERS + 1);
    localparam int MI_W   = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int SUM_W  = 33 + MAX_MEMBERS;
    localparam int PW     = gtpl_pkg::PROB_W;
    localparam int AW     = gtpl_pkg::ACC_W;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_TEST    = 4'd1;
    localparam logic [3:0] ST_SUM_RD  = 4'd2;
    localparam logic [3:0] ST_SUM_W   = 4'd3;
    localparam logic [3:0] ST_PR_M    = 4'd4;
    localparam logic [3:0] ST_PR_W    = 4'd5;
    localparam logic [3:0] ST_ACC_A   = 4'd6;
    localparam logic [3:0] ST_LOG_CHK = 4'd7;
    localparam logic [3:0] ST_NORM    = 4'd8;
    localparam logic [3:0] ST_SQ_M    = 4'd9;
    localparam logic [3:0] ST_SQ_C    = 4'd10;
    localparam logic [3:0] ST_LN_M    = 4'd11;
    localparam logic [3:0] ST_LN_A    = 4'd12;

    logic [3:0]            state_reg, state_next;
    logic [PW-1:0]         probs_reg [MAX_MEMBERS];
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [COMBOS-1:0]     vld_reg, vld_next;
    logic                  rd_vld_reg;
    logic signed [AW-1:0]  acc_reg, acc_next;
    logic [gtpl_pkg::PCNT_W-1:0] pc_reg, pc_next;
    logic                  zf_reg, zf_next;

    logic                  res_valid_reg, res_valid_next;
    logic signed [AW-1:0]  ll_reg;
    logic [gtpl_pkg::PCNT_W-1:0] rpc_reg;
    logic                  rzf_reg;
    logic                  res_load;

    // test sweep
    logic [CW:0]           rd_cnt_reg, rd_cnt_next;
    logic                  s1_v_reg, s1_v_next, s2_v_reg;
    logic                  s1_vld_reg;
    logic [CW-1:0]         s1_idx_reg, s2_idx_reg;
    logic [CW-1:0]         mask_reg;
    logic [PW-1:0]         t_inf_reg, t_clean_reg;

    // pool sum and log
    logic [CW-1:0]         ci_reg, ci_next;
    logic [CNT_W-1:0]      j_reg, j_next;
    logic [31:0]           w_reg, pr_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [30:0]           m_reg;
    logic [4:0]            e_reg;
    logic [15:0]           frac_reg;
    logic [3:0]            sq_reg;

    logic [31:0]           mul_a, mul_b;
    logic [63:0]           prod_reg;
    logic [63:0]           prod_rnd16, prod_rnd30, prod_rnd31;

    logic                  ram_we;
    logic [CW-1:0]         ram_raddr;
    logic [31:0]           ram_rdata;
    logic                  pool_clear;
    logic                  pool_done;

    logic [CW+7:0]         mask_ext;
    logic [CW-1:0]         mask_eff;
    logic [PW-1:0]         se_sat, sp_sat;
    logic [PW-1:0]         p_j, term_j;
    logic [CW:0]           combo_last;
    logic [31:0]           x_clamp;
    logic [31:0]           sq_t;
    logic [21:0]           mag;
    logic [31:0]           ln_mag;
    logic signed [AW:0]    acc_sub;

    gtpl_ram #(
        .WIDTH (32),
        .DEPTH (COMBOS)
    ) u_weights (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s2_idx_reg),
        .wdata (prod_rnd16[47:16]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign prod_rnd16 = prod_reg + 64'(1 << (gtpl_pkg::PROB_FRAC_BITS - 1));
    assign prod_rnd30 = prod_reg + 64'(1 << 30);
    assign prod_rnd31 = prod_reg + 64'h8000_0000;
    assign ram_we     = s2_v_reg;

    assign mask_ext = (CW+8)'(cmd.mask);

    always_comb
    begin
        for (int b = 0; b < CW; b++)
        begin
            mask_eff[b] = mask_ext[b] && (CNT_W'(b) < cnt_reg);
        end
    end

    assign se_sat = (se_val[cmd.assay] > gtpl_pkg::PROB_ONE) ? gtpl_pkg::PROB_ONE
                                                             : se_val[cmd.assay];
    assign sp_sat = (sp_val[cmd.assay] > gtpl_pkg::PROB_ONE) ? gtpl_pkg::PROB_ONE
                                                             : sp_val[cmd.assay];

    assign p_j        = probs_reg[j_reg[MI_W-1:0]];
    assign term_j     = ci_reg[j_reg[MI_W-1:0]] ? p_j : gtpl_pkg::PROB_ONE - p_j;
    assign combo_last = ((CW+1)'(1) << cnt_reg) - (CW+1)'(1);
    assign x_clamp    = (sum_reg > SUM_W'(gtpl_pkg::W_ONE)) ? gtpl_pkg::W_ONE : sum_reg[31:0];
    assign sq_t       = prod_reg[61:30];
    assign mag        = {1'b0, e_reg, 16'h0000} - {6'b0, frac_reg};
    assign ln_mag     = prod_rnd31[63:32];
    assign acc_sub    = {acc_reg[AW-1], acc_reg} - (AW+1)'(ln_mag);

    assign res_load = (state_reg == ST_IDLE) && cmd_valid && (cmd.op == gtpl_pkg::OP_SET)
                      && cmd_pop;

    always_comb
    begin
        cmd_pop = 1'b0;
        if (state_reg == ST_IDLE && cmd_valid)
        begin
            cmd_pop = (cmd.op != gtpl_pkg::OP_SET) || !res_valid_reg || !result_stall;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a     = 32'd0;
        mul_b     = 32'd0;
        ram_raddr = ci_reg;
        unique case (state_reg)
            ST_TEST:
            begin
                ram_raddr = rd_cnt_reg[CW-1:0];
                mul_a     = s1_vld_reg ? ram_rdata : gtpl_pkg::W_ONE;
                mul_b     = ((s1_idx_reg & mask_reg) != '0) ? 32'(t_inf_reg) : 32'(t_clean_reg);
            end
            ST_PR_M:
            begin
                if (j_reg < cnt_reg)
                begin
                    mul_a = pr_reg;
                    mul_b = 32'(term_j);
                end
                else
                begin
                    mul_a = w_reg;
                    mul_b = pr_reg;
                end
            end
            ST_SQ_M:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = {1'b0, m_reg};
            end
            ST_LN_M:
            begin
                mul_a = 32'(mag);
                mul_b = gtpl_pkg::LN2_Q32;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    // control
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        pc_next        = pc_reg;
        zf_next        = zf_reg;
        rd_cnt_next    = rd_cnt_reg;
        s1_v_next      = 1'b0;
        ci_next        = ci_reg;
        j_next         = j_reg;
        pool_clear     = 1'b0;
        pool_done      = 1'b0;
        res_valid_next = res_valid_reg && result_stall;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_pop)
                begin
                    unique case (cmd.op)
                        gtpl_pkg::OP_ADD:
                        begin
                            if (cnt_reg < CNT_W'(MAX_MEMBERS))
                            begin
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        gtpl_pkg::OP_TEST:
                        begin
                            rd_cnt_next = '0;
                            state_next  = ST_TEST;
                        end
                        gtpl_pkg::OP_POOL:
                        begin
                            ci_next    = '0;
                            state_next = ST_SUM_RD;
                        end
                        gtpl_pkg::OP_SET:
                        begin
                            acc_next   = '0;
                            pc_next    = '0;
                            zf_next    = 1'b0;
                            pool_clear = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_TEST:
            begin
                if (rd_cnt_reg != (CW+1)'(COMBOS))
                begin
                    rd_cnt_next = rd_cnt_reg + (CW+1)'(1);
                    s1_v_next   = 1'b1;
                end
                else if (!s1_v_reg && !s2_v_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM_RD:
            begin
                state_next = ST_SUM_W;
            end
            ST_SUM_W:
            begin
                j_next     = '0;
                state_next = ST_PR_M;
            end
            ST_PR_M:
            begin
                state_next = (j_reg < cnt_reg) ? ST_PR_W : ST_ACC_A;
            end
            ST_PR_W:
            begin
                j_next     = j_reg + CNT_W'(1);
                state_next = ST_PR_M;
            end
            ST_ACC_A:
            begin
                if ({1'b0, ci_reg} == combo_last)
                begin
                    state_next = ST_LOG_CHK;
                end
                else
                begin
                    ci_next    = ci_reg + CW'(1);
                    state_next = ST_SUM_RD;
                end
            end
            ST_LOG_CHK:
            begin
                if (sum_reg == '0)
                begin
                    zf_next    = 1'b1;
                    acc_next   = {1'b1, {(AW-1){1'b0}}};
                    pool_done  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (m_reg[30])
                begin
                    state_next = ST_SQ_M;
                end
            end
            ST_SQ_M:
            begin
                state_next = ST_SQ_C;
            end
            ST_SQ_C:
            begin
                state_next = (sq_reg == 4'd0) ? ST_LN_M : ST_SQ_M;
            end
            ST_LN_M:
            begin
                state_next = ST_LN_A;
            end
            ST_LN_A:
            begin
                // saturate at the most negative value on underflow
                if (acc_sub[AW] != acc_sub[AW-1])
                begin
                    acc_next = {1'b1, {(AW-1){1'b0}}};
                end
                else
                begin
                    acc_next = acc_sub[AW-1:0];
                end
                pool_done  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (pool_done)
        begin
            pool_clear = 1'b1;
            if (pc_reg != '1)
            begin
                pc_next = pc_reg + gtpl_pkg::PCNT_W'(1);
            end
        end
        if (pool_clear)
        begin
            cnt_next = '0;
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (pool_clear)
        begin
            vld_next = '0;
        end
        else if (s2_v_reg)
        begin
            vld_next[s2_idx_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            vld_reg       <= '0;
            acc_reg       <= '0;
            pc_reg        <= '0;
            zf_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
            rd_cnt_reg    <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            ci_reg        <= '0;
            j_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            vld_reg       <= vld_next;
            acc_reg       <= acc_next;
            pc_reg        <= pc_next;
            zf_reg        <= zf_next;
            res_valid_reg <= res_valid_next;
            rd_cnt_reg    <= rd_cnt_next;
            s1_v_reg      <= s1_v_next;
            s2_v_reg      <= s1_v_reg;
            ci_reg        <= ci_next;
            j_reg         <= j_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rd_vld_reg <= vld_reg[ram_raddr];
        s1_vld_reg <= vld_reg[ram_raddr];
        s1_idx_reg <= rd_cnt_reg[CW-1:0];
        s2_idx_reg <= s1_idx_reg;

        if (state_reg == ST_IDLE && cmd_pop && cmd.op == gtpl_pkg::OP_ADD
            && cnt_reg < CNT_W'(MAX_MEMBERS))
        begin
            probs_reg[cnt_reg[MI_W-1:0]] <= cmd.prob;
        end
        if (state_reg == ST_IDLE && cmd_pop && cmd.op == gtpl_pkg::OP_TEST)
        begin
            mask_reg    <= mask_eff;
            t_inf_reg   <= cmd.pos ? se_sat : gtpl_pkg::PROB_ONE - se_sat;
            t_clean_reg <= cmd.pos ? gtpl_pkg::PROB_ONE - sp_sat : sp_sat;
        end
        if (state_reg == ST_IDLE && cmd_pop && cmd.op == gtpl_pkg::OP_POOL)
        begin
            sum_reg <= '0;
        end
        if (res_load)
        begin
            ll_reg  <= acc_reg;
            rpc_reg <= pc_reg;
            rzf_reg <= zf_reg;
        end

        unique case (state_reg)
            ST_SUM_W:
            begin
                w_reg  <= rd_vld_reg ? ram_rdata : gtpl_pkg::W_ONE;
                pr_reg <= gtpl_pkg::W_ONE;
            end
            ST_PR_W:
            begin
                pr_reg <= prod_rnd16[47:16];
            end
            ST_ACC_A:
            begin
                sum_reg <= sum_reg + SUM_W'(prod_rnd30[63:31]);
            end
            ST_LOG_CHK:
            begin
                // normalize: x = 2^31 is exactly one, otherwise shift up to bit 30
                if (x_clamp[31])
                begin
                    m_reg <= 31'h4000_0000;
                    e_reg <= 5'd0;
                end
                else
                begin
                    m_reg <= x_clamp[30:0];
                    e_reg <= 5'd1;
                end
                frac_reg <= '0;
                sq_reg   <= 4'd15;
            end
            ST_NORM:
            begin
                if (!m_reg[30])
                begin
                    m_reg <= {m_reg[29:0], 1'b0};
                    e_reg <= e_reg + 5'd1;
                end
            end
            ST_SQ_C:
            begin
                if (sq_t[31])
                begin
                    m_reg            <= sq_t[31:1];
                    frac_reg[sq_reg] <= 1'b1;
                end
                else
                begin
                    m_reg <= sq_t[30:0];
                end
                sq_reg <= sq_reg - 4'd1;
            end
            default:
            begin
                w_reg <= w_reg;
            end
        endcase
    end

    assign result_valid   = res_valid_reg;
    assign log_likelihood = ll_reg;
    assign pool_count     = rpc_reg;
    assign zero_prob_seen = rzf_reg;

    a_acc_nonpositive: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg[AW-1] || (acc_reg == '0))
        else $error("log accumulator went positive");

    a_write_in_test: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_TEST))
        else $error("weight write outside a test sweep");

    a_norm_mantissa: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQ_M) |-> m_reg[30])
        else $error("log mantissa not normalized");

    a_busy_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !cmd_pop)
        else $error("command taken while engine busy");

endmodule

@@ sv/group_test_pool_loglik.sv @@
// Top level of the group-test pool likelihood engine: register port, front end, back end.
// Depends on gtpl_pkg, gtpl_front, gtpl_back and gtpl_ram.
//
// Items enter on the item channel and are queued in a four-entry command queue,
// so the source can run ahead while the engine works. Apply test sweeps all
// 2^MAX_MEMBERS combination weights through the weight RAM and the single shared
// multiplier, one weight per cycle. End pool visits the 2^n combinations of the
// n members, building each prior product one member per multiply, then takes the
// log by normalizing shifts and repeated squaring. End data set loads the result
// register; it waits only if a previous result is still held there. Sensitivity
// and specificity registers sit at byte addresses 0x00-0x0C and 0x10-0x1C; change
// them only while the engine is idle. The weight store needs no clearing pass: a
// valid bit per combination makes untouched weights read as one.
module group_test_pool_loglik #(
    parameter int MAX_MEMBERS = gtpl_pkg::MAX_MEMBERS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gtpl_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic [1:0]                         operation,
    input  logic [gtpl_pkg::PROB_W-1:0]        member_prob,
    input  logic [gtpl_pkg::MASK_W-1:0]        member_mask,
    input  logic                               test_positive,
    input  logic [1:0]                         assay,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic signed [gtpl_pkg::ACC_W-1:0]  log_likelihood,
    output logic [gtpl_pkg::PCNT_W-1:0]        pool_count,
    output logic                               zero_prob_seen
);

    logic [gtpl_pkg::PROB_W-1:0] se_reg [gtpl_pkg::REG_ASSAYS];
    logic [gtpl_pkg::PROB_W-1:0] sp_reg [gtpl_pkg::REG_ASSAYS];
    logic                        cfg_wr;
    logic [2:0]                  cfg_idx;
    logic                        cmd_valid;
    logic                        cmd_pop;
    gtpl_pkg::cmd_t              cmd;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    // Index 0..3 selects sensitivity, 4..7 specificity of the same assay.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gtpl_pkg::REG_ASSAYS; i++)
            begin
                se_reg[i] <= gtpl_pkg::PROB_ONE;
                sp_reg[i] <= gtpl_pkg::PROB_ONE;
            end
        end
        else if (cfg_wr)
        begin
            if (!cfg_idx[2])
            begin
                se_reg[cfg_idx[1:0]] <= pwdata[gtpl_pkg::PROB_W-1:0];
            end
            else
            begin
                sp_reg[cfg_idx[1:0]] <= pwdata[gtpl_pkg::PROB_W-1:0];
            end
        end
    end

    assign prdata = cfg_idx[2] ? 32'(sp_reg[cfg_idx[1:0]]) : 32'(se_reg[cfg_idx[1:0]]);

    gtpl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .operation     (operation),
        .member_prob   (member_prob),
        .member_mask   (member_mask),
        .test_positive (test_positive),
        .assay         (assay),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    gtpl_back #(
        .MAX_MEMBERS (MAX_MEMBERS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop),
        .se_val         (se_reg),
        .sp_val         (sp_reg),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .log_likelihood (log_likelihood),
        .pool_count     (pool_count),
        .zero_prob_seen (zero_prob_seen)
    );

endmodule

@@ verif/group_test_pool_loglik_tb.sv @@
// Self-checking testbench for group_test_pool_loglik: item and result channels plus APB port.
// Depends on gtpl_pkg and the group_test_pool_loglik RTL; predicts every end-of-set result.
`timescale 1ns / 100ps

module group_test_pool_loglik_tb;

    localparam int NCOMBO     = 1 << gtpl_pkg::MAX_MEMBERS_DEF;
    localparam int DRAIN_CYC  = 6000;      // longest end-pool sweep plus log, with margin
    localparam longint ACC_FLOOR = -(64'sd1 <<< 47);
    localparam int CNT_TOP    = 24'hFF_FFFF;
    localparam int PW         = gtpl_pkg::PROB_W;
    localparam int MW         = gtpl_pkg::MASK_W;
    localparam int AW         = gtpl_pkg::ADDR_W;

    // Register indexes of the APB map
    typedef enum int {
        REG_SE0 = 0, REG_SE1 = 1, REG_SE2 = 2, REG_SE3 = 3,
        REG_SP0 = 4, REG_SP1 = 5, REG_SP2 = 6, REG_SP3 = 7
    } reg_idx_t;

    typedef struct {
        logic [gtpl_pkg::ACC_W-1:0]  loglik;
        logic [gtpl_pkg::PCNT_W-1:0] pools;
        logic                        zflag;
    } set_total_t;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic item_valid = 0;
    logic item_stall;
    logic [1:0] operation = gtpl_pkg::OP_ADD;
    logic [PW-1:0] member_prob = '0;
    logic [MW-1:0] member_mask = '0;
    logic test_positive = 0;
    logic [1:0] assay = '0;
    logic result_valid;
    logic result_stall = 0;
    logic signed [gtpl_pkg::ACC_W-1:0] log_likelihood;
    logic [gtpl_pkg::PCNT_W-1:0] pool_count;
    logic zero_prob_seen;

    group_test_pool_loglik dut (.*);

    // Shadow of the engine state
    longint unsigned se_q[4], sp_q[4];
    longint unsigned prob_q[gtpl_pkg::MAX_MEMBERS_DEF];
    int unsigned     n_members;
    longint unsigned weight_q[NCOMBO];
    longint          acc_q;
    int unsigned     pools_q;
    bit              zflag_q;

    gtpl_pkg::cmd_t item_q[$];     // transactions waiting to be driven
    set_total_t total_q[$];        // set totals the engine still owes us
    int         errors = 0;
    bit         idle_on = 1;       // random gaps on both channels when set

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic longint unsigned clip_one(longint unsigned v);
        return (v > gtpl_pkg::PROB_ONE) ? longint'(gtpl_pkg::PROB_ONE) : v;
    endfunction

    function automatic longint unsigned scale_q16(longint unsigned w, longint unsigned t);
        return (w * t + (64'd1 << (gtpl_pkg::PROB_FRAC_BITS - 1))) >> gtpl_pkg::PROB_FRAC_BITS;
    endfunction

    function automatic void reset_pool();
        n_members = 0;
        foreach (weight_q[i]) weight_q[i] = gtpl_pkg::W_ONE;
    endfunction

    // Natural log of x/2^31 in Q16.16, x in 1..2^31
    function automatic longint ln_pool(longint unsigned x);
        int k;
        longint unsigned m, frac, mag;
        k = 31;
        frac = 0;
        while (k > 0 && x[k] == 1'b0) k--;
        m = (k <= 30) ? (x << (30 - k)) : (64'd1 << 30);
        for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                frac |= 64'd1 << i;
            end
        end
        mag = longint'(31 - k) * 65536 - frac;
        return -longint'((mag * longint'(gtpl_pkg::LN2_Q32) + (64'd1 << 31)) >> 32);
    endfunction

    function automatic void close_pool();
        longint unsigned sum, pr, p;
        longint l;
        sum = 0;
        for (int i = 0; i < (1 << n_members); i++) begin
            pr = gtpl_pkg::W_ONE;
            for (int j = 0; j < n_members; j++) begin
                p = clip_one(prob_q[j]);
                pr = scale_q16(pr, ((i >> j) & 1) ? p : gtpl_pkg::PROB_ONE - p);
            end
            sum += (weight_q[i] * pr + (64'd1 << 30)) >> 31;
        end
        if (sum > gtpl_pkg::W_ONE) sum = gtpl_pkg::W_ONE;
        if (sum == 0) begin
            zflag_q = 1;
            acc_q = ACC_FLOOR;
        end else begin
            l = ln_pool(sum);
            if (acc_q < ACC_FLOOR - l) acc_q = ACC_FLOOR;
            else acc_q += l;
        end
        if (pools_q < CNT_TOP) pools_q++;
        reset_pool();
    endfunction

    // Advance the shadow state by one accepted item
    function automatic void absorb_item(gtpl_pkg::cmd_t c);
        int unsigned a;
        longint unsigned se, sp, t_inf, t_clean, msk;
        set_total_t r;
        case (c.op)
            gtpl_pkg::OP_ADD: begin
                if (n_members < gtpl_pkg::MAX_MEMBERS_DEF) begin
                    prob_q[n_members] = c.prob;
                    n_members++;
                end
            end
            gtpl_pkg::OP_TEST: begin
                a = (c.assay > gtpl_pkg::NUM_ASSAYS - 1) ? gtpl_pkg::NUM_ASSAYS - 1 : c.assay;
                se = clip_one(se_q[a]);
                sp = clip_one(sp_q[a]);
                t_inf   = c.pos ? se : gtpl_pkg::PROB_ONE - se;
                t_clean = c.pos ? gtpl_pkg::PROB_ONE - sp : sp;
                msk = c.mask & ((64'd1 << n_members) - 1);
                for (int i = 0; i < NCOMBO; i++)
                    weight_q[i] = scale_q16(weight_q[i], (i & msk) ? t_inf : t_clean);
            end
            gtpl_pkg::OP_POOL: close_pool();
            default: begin
                r.loglik = acc_q[gtpl_pkg::ACC_W-1:0];
                r.pools  = pools_q[gtpl_pkg::PCNT_W-1:0];
                r.zflag  = zflag_q;
                total_q.push_back(r);
                acc_q = 0;
                pools_q = 0;
                zflag_q = 0;
                reset_pool();
            end
        endcase
    endfunction

    // Driver: present queued items, with a random hold-off drawn per transaction
    int unsigned    send_gap = 0;
    gtpl_pkg::cmd_t cur_item;
    always @(posedge clk or negedge rst_n) begin
        bit busy;
        if (!rst_n) begin
            item_valid <= 0;
            send_gap = 0;
        end else begin
            busy = item_valid;
            if (item_valid && !item_stall) begin
                absorb_item(cur_item);
                busy = 0;
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                    item_valid <= 0;
                end else if (item_q.size() > 0) begin
                    cur_item = item_q.pop_front();
                    operation     <= cur_item.op;
                    member_prob   <= cur_item.prob;
                    member_mask   <= cur_item.mask;
                    test_positive <= cur_item.pos;
                    assay         <= cur_item.assay;
                    item_valid    <= 1;
                    send_gap = idle_on ? $urandom_range(0, 10) : 0;
                end else begin
                    item_valid <= 0;
                end
            end
        end
    end

    // Monitor: check each accepted set total and throttle the result channel
    int unsigned recv_gap = 0;
    always @(posedge clk or negedge rst_n) begin
        set_total_t e;
        if (!rst_n) begin
            result_stall <= 0;
            recv_gap = 0;
        end else begin
            if (result_valid && !result_stall) begin
                if (total_q.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    e = total_q.pop_front();
                    if (log_likelihood !== e.loglik)
                        report($sformatf("log_likelihood %0d, want %0d",
                                         log_likelihood, $signed(e.loglik)));
                    if (pool_count !== e.pools)
                        report($sformatf("pool_count %0d, want %0d", pool_count, e.pools));
                    if (zero_prob_seen !== e.zflag)
                        report($sformatf("zero_prob_seen %0b, want %0b",
                                         zero_prob_seen, e.zflag));
                end
                recv_gap = idle_on ? $urandom_range(0, 10) : 0;
            end
            if (recv_gap > 0) begin
                recv_gap--;
                result_stall <= 1;
            end else begin
                result_stall <= 0;
            end
        end
    end

    function automatic void push_item(logic [1:0] op, logic [PW-1:0] prob,
                                      logic [MW-1:0] mask, logic pos, logic [1:0] as);
        gtpl_pkg::cmd_t c;
        c.op = op;
        c.prob = prob;
        c.mask = mask;
        c.pos = pos;
        c.assay = as;
        item_q.push_back(c);
    endfunction

    function automatic void push_test();
        push_item(gtpl_pkg::OP_TEST, PW'($urandom), MW'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    endfunction

    // One pool with random content; mostly small, now and then full or overfull
    function automatic int gen_pool();
        int n, tests, cnt;
        cnt = 0;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
        tests = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            if (tests > 0 && $urandom_range(0, 3) == 0) begin
                push_test();
                tests--;
                cnt++;
            end
            // mostly in range, sometimes above one so the upper bit toggles
            push_item(gtpl_pkg::OP_ADD,
                      ($urandom_range(0, 7) == 0) ? PW'($urandom_range(0, 131071))
                                                  : PW'($urandom_range(0, 65536)),
                      MW'($urandom), 1'($urandom), 2'($urandom));
            cnt++;
        end
        repeat (tests) begin
            push_test();
            cnt++;
        end
        // noise: a fully random item
        if ($urandom_range(0, 9) == 0) begin
            push_item(2'($urandom), PW'($urandom), MW'($urandom), 1'($urandom), 2'($urandom));
            cnt++;
        end
        if ($urandom_range(0, 9) != 0) begin
            push_item(gtpl_pkg::OP_POOL, PW'($urandom), MW'($urandom), 1'($urandom),
                      2'($urandom));
            cnt++;
        end
        if ($urandom_range(0, 5) == 0) begin
            push_item(gtpl_pkg::OP_SET, PW'($urandom), MW'($urandom), 1'($urandom),
                      2'($urandom));
            cnt++;
        end
        return cnt;
    endfunction

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1;
        pwrite  <= 1;
        penable <= 0;
        paddr   <= AW'(4 * idx);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        if (idx < REG_SP0) se_q[idx] = val[PW-1:0];
        else sp_q[idx - REG_SP0] = val[PW-1:0];
    endtask

    // Wait until every item is in and every set total is out, then let a pool close
    task automatic drain();
        while (item_q.size() > 0 || item_valid || total_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    initial begin
        int made;
        foreach (se_q[i]) begin
            se_q[i] = gtpl_pkg::PROB_ONE;
            sp_q[i] = gtpl_pkg::PROB_ONE;
        end
        foreach (prob_q[i]) prob_q[i] = 0;
        reset_pool();
        acc_q = 0;
        pools_q = 0;
        zflag_q = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // Directed part at reset settings (perfect assays)
        push_item(gtpl_pkg::OP_POOL, 0, 0, 0, 0);        // empty pool: log of one
        push_item(gtpl_pkg::OP_TEST, 0, 8'h00, 1, 0);    // positive on empty subset: zero pool
        push_item(gtpl_pkg::OP_POOL, 0, 0, 0, 0);
        push_item(gtpl_pkg::OP_ADD, 17'd0, 0, 0, 0);     // accumulator already at floor
        push_item(gtpl_pkg::OP_POOL, 0, 0, 0, 0);
        push_item(gtpl_pkg::OP_SET, 0, 0, 0, 0);
        push_item(gtpl_pkg::OP_TEST, 0, 8'hFF, 0, 3);    // test before later members
        for (int i = 0; i < 9; i++)                      // ninth add hits a full pool
            push_item(gtpl_pkg::OP_ADD,
                      (i == 0) ? 17'd65536 : (i == 1) ? 17'h1FFFF : PW'(3000 * i),
                      0, 0, 0);
        push_item(gtpl_pkg::OP_TEST, 0, 8'hFF, 1, 1);
        push_item(gtpl_pkg::OP_TEST, 0, 8'h01, 0, 2);
        push_item(gtpl_pkg::OP_POOL, 0, 0, 0, 0);
        push_item(gtpl_pkg::OP_ADD, 17'd40000, 0, 0, 0); // left unfinished, cleared by end of set
        push_item(gtpl_pkg::OP_SET, 0, 0, 0, 0);
        drain();

        // Random phases, each with its own assay settings
        for (int ph = 0; ph < 5; ph++) begin
            for (int r = REG_SE0; r <= REG_SP3; r++) begin
                case (ph)
                    0: apb_write(reg_idx_t'(r), 32'd0);
                    1: apb_write(reg_idx_t'(r), 32'h1FFFF);
                    2: apb_write(reg_idx_t'(r), (r & 1) ? 32'd65536 : 32'd0);
                    default: apb_write(reg_idx_t'(r), $urandom_range(50000, 65536));
                endcase
            end
            idle_on = (ph != 3);
            made = 0;
            while (made < 290) made += gen_pool();
            push_item(gtpl_pkg::OP_POOL, 0, 0, 0, 0);
            push_item(gtpl_pkg::OP_SET, 0, 0, 0, 0);
            drain();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
